// File: rtl/prime_range_count_and_sum_macros.svh
// Assertion macros shared by the prime range counter RTL.
`ifndef PRIME_RANGE_COUNT_AND_SUM_MACROS_SVH
`define PRIME_RANGE_COUNT_AND_SUM_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define PRCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define PRCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/prcs_pkg.sv
// Shared widths and controller/datapath command and status types.
`default_nettype none

package prcs_pkg;

  // Field widths of the query and result items
  localparam int unsigned FIELD_W       = 16;
  localparam int unsigned COUNT_W       = 13;
  localparam int unsigned SUM_W         = 28;
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SUM_W-1:0]   sum_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_query;  // capture bounds, clear totals
    logic init_trial;  // divisor to two, square to four
    logic start_div;   // clear remainder, point at top bit
    logic div_step;    // one restoring remainder step
    logic next_trial;  // advance divisor and its square
    logic accumulate;  // add candidate to the totals
    logic next_cand;   // advance candidate
    logic load_out;    // move totals to the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;       // query bounds give an empty range
    logic lt_two;      // candidate below two
    logic sq_gt_v;     // divisor squared exceeds candidate
    logic div_last;    // last remainder step this cycle
    logic rem_zero;    // remainder is zero
    logic is_last;     // candidate equals the upper bound
    logic out_free;    // result register can take a new result
  } status_t;

endpackage

`default_nettype wire

// File: rtl/prcs_query_if.sv
// Query channel: range bounds with valid/ready handshake.
`default_nettype none

interface prcs_query_if;
  import prcs_pkg::*;

  logic   valid;
  logic   ready;
  field_t range_low;
  field_t range_high;

  modport source (output valid, output range_low, output range_high, input ready);
  modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

`default_nettype wire

// File: rtl/prcs_result_if.sv
// Result channel: prime count and sum with valid/ready handshake.
`default_nettype none

interface prcs_result_if;
  import prcs_pkg::*;

  logic   valid;
  logic   ready;
  count_t prime_count;
  sum_t   prime_sum;

  modport source (output valid, output prime_count, output prime_sum, input ready);
  modport sink   (input valid, input prime_count, input prime_sum, output ready);
endinterface

`default_nettype wire

// File: rtl/prime_range_count_and_sum.sv
// Top level: counts and sums the primes in a closed range by trial division.
//
//   channel   dir  payload                       handshake
//   query_i   in   range_low, range_high          valid / ready
//   result_o  out  prime_count, prime_sum         valid / ready
//
// Per candidate: set up the trial, then for each trial divisor a test, the remainder
// steps and an evaluation, then advance to the next candidate. The remainder steps run
// on the single bit-serial remainder unit, one bit per cycle over EW = min(VALUE_WIDTH, 16) bits.
// One query is worked at a time; query_i.ready is high only while no walk runs and
// no finished result waits to enter the result register.
// A result waits in its output register; a stalled result_o holds it there.
// Reset is asynchronous, active low, and leaves the block idle with no result.
`default_nettype none

`include "prime_range_count_and_sum_macros.svh"

module prime_range_count_and_sum #(
  parameter int unsigned VALUE_WIDTH = prcs_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  prcs_query_if.sink     query_i,
  prcs_result_if.source  result_o
);
  import prcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  prcs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .query_valid_i (query_i.valid),
    .query_ready_o (query_i.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  prcs_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .range_low_i    (query_i.range_low),
    .range_high_i   (query_i.range_high),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_ready_i (result_o.ready),
    .result_valid_o (result_o.valid),
    .prime_count_o  (result_o.prime_count),
    .prime_sum_o    (result_o.prime_sum)
  );

  // A query transfer starts a walk or, for an empty range, a pending result: no second query right behind it
  `PRCS_ASSERT(a_busy_after_query, clk_i, rst_ni, query_i.valid && query_i.ready |=> !query_i.ready, "query accepted while busy")
  // A finished result shows up on the result channel next cycle
  `PRCS_ASSERT(a_result_follows_load, clk_i, rst_ni, cmd.load_out |=> result_o.valid, "result load lost")
  // Never overwrite a result that has not been taken
  `PRCS_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.load_out && result_o.valid && !result_o.ready, "pending result overwritten")

endmodule

`default_nettype wire

// File: rtl/prcs_ctrl.sv
// Controller state machine sequencing the range walk and trial division.
`default_nettype none

module prcs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              query_valid_i,
  output logic                   query_ready_o,
  input  wire prcs_pkg::status_t status_i,
  output prcs_pkg::cmd_t         cmd_o
);
  import prcs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CAND = 6'b000010,
    S_TEST = 6'b000100,
    S_DIV  = 6'b001000,
    S_EVAL = 6'b010000,
    S_NEXT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;   // result pending in S_IDLE

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    fin_d         = fin_q;
    cmd_o         = '0;
    query_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (fin_q) begin
          // hold until the result register frees up
          if (status_i.out_free) begin
            cmd_o.load_out = 1'b1;
            fin_d          = 1'b0;
          end
        end else begin
          query_ready_o = 1'b1;
          if (query_valid_i) begin
            cmd_o.load_query = 1'b1;
            if (status_i.empty) begin
              fin_d = 1'b1;
            end else begin
              state_d = S_CAND;
            end
          end
        end
      end
      S_CAND: begin
        cmd_o.init_trial = 1'b1;
        state_d          = S_TEST;
      end
      S_TEST: begin
        if (status_i.lt_two) begin
          state_d = S_NEXT;
        end else if (status_i.sq_gt_v) begin
          cmd_o.accumulate = 1'b1;
          state_d          = S_NEXT;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status_i.rem_zero) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.next_trial = 1'b1;
          state_d          = S_TEST;
        end
      end
      S_NEXT: begin
        if (status_i.is_last) begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.next_cand = 1'b1;
          state_d         = S_CAND;
        end
      end
      default: begin
        state_d = S_IDLE;
        fin_d   = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/prcs_datapath.sv
// Datapath: candidate walk, bit-serial remainder unit, totals, result register.
`default_nettype none

module prcs_datapath #(
  parameter int unsigned VALUE_WIDTH = prcs_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire prcs_pkg::field_t  range_low_i,
  input  wire prcs_pkg::field_t  range_high_i,
  input  wire prcs_pkg::cmd_t    cmd_i,
  output prcs_pkg::status_t      status_o,
  input  wire logic              result_ready_i,
  output logic                   result_valid_o,
  output prcs_pkg::count_t       prime_count_o,
  output prcs_pkg::sum_t         prime_sum_o
);
  import prcs_pkg::*;

  // Effective value width: inputs are limited to the field width
  localparam int unsigned EW    = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int unsigned CNT_W = (EW > 1) ? $clog2(EW) : 1;
  localparam int unsigned SQ_W  = EW + 2;

  logic [EW-1:0]    cand_q, cand_d;
  logic [EW-1:0]    high_q, high_d;
  logic [EW-1:0]    div_q, div_d;
  logic [SQ_W-1:0]  sq_q, sq_d;
  logic [EW-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0] bit_q, bit_d;
  count_t           count_q, count_d;
  sum_t             sum_q, sum_d;
  logic             out_valid_q, out_valid_d;
  count_t           out_count_q, out_count_d;
  sum_t             out_sum_q, out_sum_d;

  logic [EW-1:0]    low_in, high_in;
  logic [EW:0]      shifted, diff;

  assign low_in  = range_low_i[EW-1:0];
  assign high_in = range_high_i[EW-1:0];

  // One restoring remainder step: shift in the next candidate bit
  assign shifted = {rem_q, cand_q[bit_q]};
  assign diff    = shifted - {1'b0, div_q};

  // Status toward the controller
  always_comb begin
    status_o.empty    = low_in > high_in;
    status_o.lt_two   = cand_q < EW'(2);
    status_o.sq_gt_v  = sq_q > {2'b00, cand_q};
    status_o.div_last = bit_q == '0;
    status_o.rem_zero = rem_q == '0;
    status_o.is_last  = cand_q == high_q;
    status_o.out_free = !out_valid_q || result_ready_i;
  end

  // Working registers
  always_comb begin
    cand_d  = cand_q;
    high_d  = high_q;
    div_d   = div_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    count_d = count_q;
    sum_d   = sum_q;
    if (cmd_i.load_query) begin
      cand_d  = low_in;
      high_d  = high_in;
      count_d = '0;
      sum_d   = '0;
    end
    if (cmd_i.init_trial) begin
      div_d = EW'(2);
      sq_d  = SQ_W'(4);
    end
    if (cmd_i.start_div) begin
      rem_d = '0;
      bit_d = CNT_W'(EW - 1);
    end
    if (cmd_i.div_step) begin
      rem_d = shifted[EW] || !diff[EW] ? diff[EW-1:0] : shifted[EW-1:0];
      bit_d = bit_q - 1'b1;
    end
    if (cmd_i.next_trial) begin
      // (d+1)^2 = d^2 + 2d + 1
      div_d = div_q + 1'b1;
      sq_d  = sq_q + {1'b0, div_q, 1'b1};
    end
    if (cmd_i.accumulate) begin
      count_d = count_q + 1'b1;
      sum_d   = sum_q + {{(SUM_W - EW){1'b0}}, cand_q};
    end
    if (cmd_i.next_cand) begin
      cand_d = cand_q + 1'b1;
    end
  end

  // Result register with its own valid
  always_comb begin
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    out_sum_d   = out_sum_q;
    if (out_valid_q && result_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_count_d = cmd_i.load_query ? '0 : count_q;
      out_sum_d   = cmd_i.load_query ? '0 : sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    high_q      <= high_d;
    div_q       <= div_d;
    sq_q        <= sq_d;
    rem_q       <= rem_d;
    bit_q       <= bit_d;
    count_q     <= count_d;
    sum_q       <= sum_d;
    out_count_q <= out_count_d;
    out_sum_q   <= out_sum_d;
  end

  assign result_valid_o = out_valid_q;
  assign prime_count_o  = out_count_q;
  assign prime_sum_o    = out_sum_q;

endmodule

`default_nettype wire

// File: dv/prime_range_count_and_sum_tb.sv
// Self-checking testbench for the prime range counter: random queries, stalls and scoreboard.
`timescale 1ns / 1ps

module prime_range_count_and_sum_tb;
  import prcs_pkg::*;

  // Query waiting to be driven; hold_for_drain holds it back until nothing is in flight
  typedef struct {
    field_t lo;
    field_t hi;
    bit     hold_for_drain;
  } range_query_t;

  // Predicted answer for one accepted query
  typedef struct {
    field_t lo;
    field_t hi;
    count_t count;
    sum_t   total;
  } prime_tally_t;

  localparam int unsigned IDLE_PCT      = 21;
  localparam int unsigned SINK_HOLD_CYC = 3000;
  localparam int unsigned TAIL_CYC      = 100;

  logic clk_i;
  logic rst_ni;

  prcs_query_if  query_bus ();
  prcs_result_if result_bus ();

  prime_range_count_and_sum uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .query_i  (query_bus),
    .result_o (result_bus)
  );

  range_query_t query_backlog[$];
  prime_tally_t expected_tallies[$];

  int unsigned queries_sent    = 0;
  int unsigned tallies_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned sink_hold_left  = 0;
  bit          sink_hold_done  = 1'b0;

  // Count and sum the primes in [lo, hi] by trial division
  function automatic prime_tally_t tally_primes(input field_t lo, input field_t hi);
    prime_tally_t t;
    int unsigned  v;
    int unsigned  d;
    bit           is_prime;
    t.lo    = lo;
    t.hi    = hi;
    t.count = '0;
    t.total = '0;
    for (v = lo; v <= hi; v++) begin
      is_prime = (v >= 2);
      for (d = 2; is_prime && d * d <= v; d++) begin
        if (v % d == 0) is_prime = 1'b0;
      end
      if (is_prime) begin
        t.count = count_t'(t.count + 1);
        t.total = sum_t'(t.total + v);
      end
    end
    return t;
  endfunction

  task automatic add_query(input int unsigned lo, input int unsigned hi, input bit drain);
    range_query_t q;
    q.lo             = field_t'(lo);
    q.hi             = field_t'(hi);
    q.hold_for_drain = drain;
    query_backlog.push_back(q);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run timeout
  initial begin
    #40_000_000;
    $display("%0t: timeout with %0d of %0d queries answered", $time, tallies_checked,
             queries_sent);
    $display("*** FAILED ***");
    $finish;
  end

  // Query driver: present the next backlog entry unless idling or waiting for a drain
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_bus.valid      <= 1'b0;
      query_bus.range_low  <= '0;
      query_bus.range_high <= '0;
    end else if (!query_bus.valid || query_bus.ready) begin
      if (query_backlog.size() != 0 &&
          !(query_backlog[0].hold_for_drain &&
            queries_sent + (query_bus.valid && query_bus.ready) != tallies_checked) &&
          ((queries_sent >= 50 && queries_sent < 75) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        query_bus.valid      <= 1'b1;
        query_bus.range_low  <= query_backlog[0].lo;
        query_bus.range_high <= query_backlog[0].hi;
        void'(query_backlog.pop_front());
      end else begin
        query_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink: random back-pressure, one long hold-off early in the run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      sink_hold_left   <= 0;
      sink_hold_done   <= 1'b0;
    end else if (sink_hold_left != 0) begin
      result_bus.ready <= 1'b0;
      sink_hold_left   <= sink_hold_left - 1;
    end else if (!sink_hold_done && tallies_checked == 3) begin
      result_bus.ready <= 1'b0;
      sink_hold_left   <= SINK_HOLD_CYC;
      sink_hold_done   <= 1'b1;
    end else begin
      result_bus.ready <= (tallies_checked >= 50 && tallies_checked < 75) ||
                          ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on each query transfer, check each result transfer
  always @(posedge clk_i) begin
    prime_tally_t want;
    if (rst_ni) begin
      if (query_bus.valid && query_bus.ready) begin
        expected_tallies.push_back(tally_primes(query_bus.range_low, query_bus.range_high));
        queries_sent <= queries_sent + 1;
      end
      if (result_bus.valid && result_bus.ready) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result: expected none, got count %0d sum %0d", $time,
                   result_bus.prime_count, result_bus.prime_sum);
          mismatches++;
        end else begin
          want = expected_tallies.pop_front();
          if (result_bus.prime_count !== want.count) begin
            $display("%0t: prime_count for [%0d..%0d]: expected %0d, got %0d", $time,
                     want.lo, want.hi, want.count, result_bus.prime_count);
            mismatches++;
          end
          if (result_bus.prime_sum !== want.total) begin
            $display("%0t: prime_sum for [%0d..%0d]: expected %0d, got %0d", $time,
                     want.lo, want.hi, want.total, result_bus.prime_sum);
            mismatches++;
          end
        end
        tallies_checked <= tallies_checked + 1;
      end
    end
  end

  // Stimulus, reset and final verdict
  initial begin
    int unsigned query_total;
    int unsigned sel;
    int unsigned lo;
    int unsigned span;
    rst_ni = 1'b0;

    // Directed: values below two, smallest primes, squares, empty ranges, field extremes
    add_query(0, 0, 1'b0);
    add_query(1, 1, 1'b0);
    add_query(0, 1, 1'b0);
    add_query(2, 2, 1'b0);
    add_query(3, 3, 1'b0);
    add_query(4, 4, 1'b0);
    add_query(1, 2, 1'b0);
    add_query(0, 30, 1'b0);
    add_query(25, 25, 1'b0);
    add_query(49, 49, 1'b0);
    add_query(121, 121, 1'b0);
    add_query(100, 99, 1'b0);
    add_query(65535, 0, 1'b1);
    add_query(65535, 65534, 1'b0);
    add_query(65535, 65535, 1'b0);
    add_query(65521, 65535, 1'b0);
    add_query(0, 1000, 1'b0);
    add_query(16'hAAAA, 16'hAAB8, 1'b0);
    add_query(16'h5555, 16'h5570, 1'b0);
    add_query(16'h7FF0, 16'h7FFF, 1'b0);
    add_query(16'h8000, 16'h8010, 1'b0);

    // Random: mostly short ranges anywhere or low down, some wider, some empty
    for (int i = 0; i < 80; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        lo = $urandom_range(1, 65535);
        add_query(lo, $urandom_range(0, lo - 1), i == 0 || i == 60);
      end else begin
        lo   = (sel < 55) ? $urandom_range(0, 65535) : $urandom_range(0, 1023);
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
        add_query(lo, (lo + span > 65535) ? 65535 : lo + span, i == 0 || i == 60);
      end
    end
    query_total = query_backlog.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every answer, then give stray results a chance to show
    wait (tallies_checked == query_total);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (mismatches == 0 && expected_tallies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/prcs_pkg.sv
rtl/prcs_query_if.sv
rtl/prcs_result_if.sv
rtl/prcs_ctrl.sv
rtl/prcs_datapath.sv
rtl/prime_range_count_and_sum.sv
dv/prime_range_count_and_sum_tb.sv
